### hdl/fgpf_pkg.sv
// Shared types and constants of the free-gap placement finder.
`default_nettype none

package fgpf_pkg;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Result kind codes.
  typedef enum logic [1:0] {
    KIND_IN_PLACE = 2'd0,
    KIND_GAP      = 2'd1,
    KIND_END      = 2'd2,
    KIND_BAD_SLOT = 2'd3
  } place_kind_t;

  // Configuration register indexes.
  localparam logic CFG_END_POSITION = 1'b0;
  localparam logic CFG_TOC_TYPE     = 1'b1;

  localparam logic [63:0] NO_NEXT = 64'hFFFF_FFFF_FFFF_FFFF;

  // What one pass over the table looks for.
  typedef enum logic [1:0] {
    SCAN_REUSE = 2'd0,  // nearest later start of a non-TOC extent
    SCAN_MIN   = 2'd1,  // first extent in (start, slot) order
    SCAN_SUCC  = 2'd2   // successor of the current extent in that order
  } scan_mode_t;

  typedef struct packed {
    logic        scan_start;
    scan_mode_t  scan_mode;
    logic        load_cur;
    logic        take_best;
    logic        step_clr;
    logic        step_inc;
    logic        calc;
    logic        out_load;
    place_kind_t out_kind;
  } fgpf_cmd_t;

  typedef struct packed {
    logic query_in;
    logic q_reuse;
    logic bad_slot;
    logic lt2;
    logic scan_done;
    logic reuse_ok;
    logic fits;
    logic last_pair;
    logic out_free;
  } fgpf_sts_t;

endpackage

`default_nettype wire

### hdl/fgpf_ctrl.sv
// Sequencing state machine of the free-gap placement finder.
`default_nettype none

module fgpf_ctrl
  import fgpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fgpf_sts_t sts,
  output fgpf_cmd_t      cmd,
  output logic           in_ready
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_BEGIN  = 11'b000_0000_0010,
    ST_R_LD   = 11'b000_0000_0100,
    ST_R_SCAN = 11'b000_0000_1000,
    ST_R_DEC  = 11'b000_0001_0000,
    ST_F_MIN  = 11'b000_0010_0000,
    ST_F_NEXT = 11'b000_0100_0000,
    ST_F_SCAN = 11'b000_1000_0000,
    ST_F_GAP  = 11'b001_0000_0000,
    ST_F_CHK  = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t      state, state_next;
  place_kind_t res_kind, res_kind_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    cmd           = '0;
    cmd.scan_mode = SCAN_MIN;
    cmd.out_kind  = res_kind;
    case (state)
      ST_IDLE: begin
        if (sts.query_in) state_next = ST_BEGIN;
      end
      ST_BEGIN: begin
        if (sts.q_reuse && sts.bad_slot) begin
          res_kind_next = KIND_BAD_SLOT;
          state_next    = ST_DONE;
        end else if (sts.q_reuse) begin
          state_next = ST_R_LD;
        end else if (sts.lt2) begin
          res_kind_next = KIND_END;
          state_next    = ST_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_F_MIN;
        end
      end
      ST_R_LD: begin
        cmd.load_cur   = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SCAN_REUSE;
        state_next     = ST_R_SCAN;
      end
      ST_R_SCAN: begin
        if (sts.scan_done) state_next = ST_R_DEC;
      end
      ST_R_DEC: begin
        if (sts.reuse_ok) begin
          res_kind_next = KIND_IN_PLACE;
          state_next    = ST_DONE;
        end else if (sts.lt2) begin
          res_kind_next = KIND_END;
          state_next    = ST_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_F_MIN;
        end
      end
      ST_F_MIN: begin
        if (sts.scan_done) begin
          cmd.step_clr = 1'b1;
          state_next   = ST_F_NEXT;
        end
      end
      ST_F_NEXT: begin
        cmd.take_best  = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = SCAN_SUCC;
        state_next     = ST_F_SCAN;
      end
      ST_F_SCAN: begin
        if (sts.scan_done) state_next = ST_F_GAP;
      end
      ST_F_GAP: begin
        cmd.calc   = 1'b1;
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (sts.fits) begin
          res_kind_next = KIND_GAP;
          state_next    = ST_DONE;
        end else if (sts.last_pair) begin
          res_kind_next = KIND_END;
          state_next    = ST_DONE;
        end else begin
          cmd.step_inc = 1'b1;
          state_next   = ST_F_NEXT;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_kind <= KIND_END;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

`ifndef ASSERT_OFF
  a_scan_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> !in_ready)
    else $error("scan started while idle");
  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> in_ready)
    else $error("result loaded without return to idle");
  a_done_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DONE) |-> ($past(state) != ST_IDLE))
    else $error("result state entered from idle");
`endif

endmodule

`default_nettype wire

### hdl/fgpf_dp.sv
// Extent table, scan unit and result register of the free-gap placement finder.
`default_nettype none

module fgpf_dp
  import fgpf_pkg::*;
#(
  parameter int MAX_EXTENTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [63:0]   cfg_data,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire logic [1:0]    in_action,
  input  wire logic [63:0]   in_start,
  input  wire logic [31:0]   in_length,
  input  wire logic [7:0]    in_kind,
  input  wire logic          in_reuse_valid,
  input  wire logic [5:0]    in_reuse_slot,
  input  wire logic [63:0]   in_request,
  input  wire fgpf_cmd_t     cmd,
  output fgpf_sts_t          sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        out_position,
  output logic [1:0]         out_kind
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  logic [63:0] st_mem [MAX_EXTENTS];
  logic [31:0] ln_mem [MAX_EXTENTS];
  logic [7:0]  kd_mem [MAX_EXTENTS];

  logic [CW-1:0] count, step;
  logic [63:0]   end_pos;
  logic [7:0]    toc_type;
  logic          q_reuse;
  logic [5:0]    q_slot;
  logic [63:0]   q_req;

  logic [AW-1:0] idx, rd_i, rd_addr;
  logic          run, rd_v;
  logic [63:0]   rd_st;
  logic [31:0]   rd_ln;
  logic [7:0]    rd_kd;
  scan_mode_t    mode;

  logic [63:0]   cur_s, best_s, gap, pos;
  logic [31:0]   cur_ln, best_ln;
  logic [AW-1:0] cur_i, best_i;
  logic          found;

  logic          accept, take;
  logic [63:0]   span;

  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_pos  <= '0;
      toc_type <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_END_POSITION: end_pos  <= cfg_data;
        CFG_TOC_TYPE:     toc_type <= cfg_data[7:0];
        default:          end_pos  <= end_pos;
      endcase
    end
  end

  // Fill count: clear empties the table, append adds one extent if room.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (action_t'(in_action) == ACT_CLEAR) begin
        count <= '0;
      end else if (action_t'(in_action) == ACT_APPEND && count < CW'(MAX_EXTENTS)) begin
        count <= count + CW'(1);
      end
    end
  end

  // Table memories: one write port for appends, one registered read port.
  assign rd_addr = run ? idx : AW'(q_slot);
  always_ff @(posedge clk) begin
    if (accept && action_t'(in_action) == ACT_APPEND && count < CW'(MAX_EXTENTS)) begin
      st_mem[count[AW-1:0]] <= in_start;
      ln_mem[count[AW-1:0]] <= in_length;
      kd_mem[count[AW-1:0]] <= in_kind;
    end
    rd_st <= st_mem[rd_addr];
    rd_ln <= ln_mem[rd_addr];
    rd_kd <= kd_mem[rd_addr];
  end

  // Query fields are held for the whole search.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_reuse <= in_reuse_valid;
      q_slot  <= in_reuse_slot;
      q_req   <= in_request;
    end
  end

  // Scan sequencer: issue one read a cycle over all stored slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= run;
      if (cmd.scan_start) begin
        run <= 1'b1;
      end else if (run && CW'(idx) == count - CW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_i <= idx;
    if (cmd.scan_start) begin
      idx  <= '0;
      mode <= cmd.scan_mode;
    end else if (run) begin
      idx <= idx + AW'(1);
    end
  end

  // Candidate test for the entry whose data has just come back.
  always_comb begin
    take = 1'b0;
    case (mode)
      SCAN_REUSE: take = (rd_kd != toc_type) && (rd_st > cur_s) && (rd_st < best_s);
      SCAN_MIN:   take = !found || (rd_st < best_s);
      SCAN_SUCC:  take = ((rd_st > cur_s) || (rd_st == cur_s && rd_i > cur_i))
                         && (!found || rd_st < best_s);
      default:    take = 1'b0;
    endcase
  end

  // Best candidate and current extent.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found  <= 1'b0;
      best_s <= NO_NEXT;
    end else if (rd_v && take) begin
      found   <= 1'b1;
      best_s  <= rd_st;
      best_ln <= rd_ln;
      best_i  <= rd_i;
    end
    if (cmd.load_cur) begin
      cur_s <= rd_st;
    end else if (cmd.take_best) begin
      cur_s  <= best_s;
      cur_ln <= best_ln;
      cur_i  <= best_i;
    end
  end

  // Gap between the current extent and its successor, and the found position.
  assign span = best_s - cur_s;
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (best_s <= cur_s || span <= {32'd0, cur_ln}) begin
        gap <= '0;
      end else begin
        gap <= span - {32'd0, cur_ln};
      end
      pos <= cur_s + {32'd0, cur_ln};
    end
  end

  // Pair counter of the ordered walk.
  always_ff @(posedge clk) begin
    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + CW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= cmd.out_kind;
      case (cmd.out_kind)
        KIND_IN_PLACE: out_position <= cur_s;
        KIND_GAP:      out_position <= pos;
        KIND_END:      out_position <= end_pos;
        default:       out_position <= '0;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.query_in  = in_valid && action_t'(in_action) == ACT_QUERY;
    sts.q_reuse   = q_reuse;
    sts.bad_slot  = {2'b00, q_slot} >= 8'(count);
    sts.lt2       = count < CW'(2);
    sts.scan_done = rd_v && CW'(rd_i) == count - CW'(1);
    sts.reuse_ok  = (best_s == NO_NEXT) || (span >= q_req);
    sts.fits      = gap >= q_req;
    sts.last_pair = ((CW+1)'(step) + (CW+1)'(2)) == (CW+1)'(count);
    sts.out_free  = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS))
    else $error("fill count beyond table depth");
  a_read_in_table: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> CW'(rd_i) < count)
    else $error("scan read beyond stored entries");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

### hdl/free_gap_placement_finder.sv
// Top level of the free-gap placement finder.
`default_nettype none

// Keeps a table of up to MAX_EXTENTS extents (start, length, type) and answers
// placement queries with first-fit over ascending start order. Clear and
// append items give no result. A query is worked by one table read port: a
// rewritten entry takes one pass over the table, and the ordered walk takes
// one pass to find the first extent and one pass per extent pair it checks.
// The block takes one item at a time; a finished result waits in an output
// register.
module free_gap_placement_finder
  import fgpf_pkg::*;
#(
  parameter int MAX_EXTENTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // extent_start, extent_length, extent_kind, reuse_valid, reuse_slot, request_size
  input  wire logic [175:0] s_axis_tdata,
  // action
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // place_position
  output logic [63:0]       m_axis_tdata,
  // place_kind
  output logic [1:0]        m_axis_tuser
);

  fgpf_cmd_t cmd;
  fgpf_sts_t sts;

  fgpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_axis_tready)
  );

  fgpf_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_action      (s_axis_tuser),
    .in_start       (s_axis_tdata[63:0]),
    .in_length      (s_axis_tdata[95:64]),
    .in_kind        (s_axis_tdata[103:96]),
    .in_reuse_valid (s_axis_tdata[104]),
    .in_reuse_slot  (s_axis_tdata[110:105]),
    .in_request     (s_axis_tdata[174:111]),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_position   (m_axis_tdata),
    .out_kind       (m_axis_tuser)
  );

endmodule

`default_nettype wire
